/* rtl/tldda_pkg.sv */
package tldda_pkg;

  // field widths of one request and of the registers
  localparam int START_W    = 20;
  localparam int DIR_W      = 16;
  localparam int THICK_W    = 3;
  localparam int LEN_W      = 6;
  localparam int MAPW_W     = 12;

  // fixed-point formats of the inputs
  localparam int START_FRAC = 8;
  localparam int DIR_FRAC   = 14;

  // magnitude of a direction component, -32768 included
  localparam int MAG_W      = 16;
  // integer bits of a walked position, sign included
  localparam int INT_W      = 14;
  // signed width of direction times thickness
  localparam int PERP_W     = 20;
  // width of the step count before saturation
  localparam int STEP_RAW_W = MAG_W + LEN_W - DIR_FRAC;
  localparam int MAX_STEPS  = 63;

  localparam int IN_DATA_W  = 80;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XLIM = 2'd1;

  localparam logic [LEN_W-1:0]  LEN_RST  = 6'd30;
  localparam logic [MAPW_W-1:0] XLIM_RST = 12'd640;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVX,
    ST_DIVY,
    ST_WALK
  } tldda_state_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

endpackage

/* rtl/thick_line_dda_rasterizer.sv */
// Draws one line per request: the origin is shifted across the direction by
// the thickness, then walked for trunc(max(|dir_x|,|dir_y|) * length) steps
// (at most 63), one pixel beat per step, tlast on the final pixel and
// stopping early once x reaches the x limit. A request passes a setup state,
// then two passes of a shared restoring divider for the x and y increments,
// then the walk at one cycle per pixel while out_tready is high, and then
// returns to idle. Requests whose start x is at or past the x limit or that
// have zero steps return to ready straight from the setup state. The divider
// is the only iterative part; in_tready stays low until the walk of the
// previous line has finished, while its last pixel may still wait in the
// output register.
module thick_line_dda_rasterizer #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x[19:0], start_y[39:20], dir_x[55:40], dir_y[71:56], thickness[74:72]
  input  logic [tldda_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_x, pixel_y, each COORD_BITS wide, zero padded to whole bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tldda_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tldda_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tldda_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
  localparam int POS_W = FRAC_BITS + INT_W;
  localparam int INC_W = FRAC_BITS + 2;

  tldda_state_t state_r, state_nxt;

  logic [LEN_W-1:0]          ll_r;
  logic [MAPW_W-1:0]         mw_r;

  logic [START_W-1:0]        sx_r, sy_r;
  logic signed [DIR_W-1:0]   dx_r, dy_r;
  logic signed [THICK_W-1:0] th_r;

  logic [MAG_W-1:0]          m_r;
  logic [LEN_W-1:0]          steps_r;
  logic signed [POS_W-1:0]   pos_x_r, pos_y_r;
  logic signed [INC_W-1:0]   inc_x_r;

  logic [MAG_W-1:0]          ax, ay, m;
  logic [MAG_W+LEN_W-1:0]    prod;
  logic [STEP_RAW_W-1:0]     steps_raw;
  logic [LEN_W-1:0]          steps;
  logic                      start_ok;
  logic signed [PERP_W-1:0]  perp_x, perp_y;
  logic signed [POS_W-1:0]   perp_x_f, perp_y_f;
  logic signed [POS_W-1:0]   sx_f, sy_f;
  logic signed [INC_W-1:0]   inc_w;

  div_req_t                  div_req;
  logic                      div_done;
  logic [FRAC_BITS:0]        div_q;
  logic                      walk_load;
  logic                      walk_busy;
  logic [COORD_BITS-1:0]     pixel_x, pixel_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_r <= LEN_RST;
      mw_r <= XLIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEN:  ll_r <= cfg_data[LEN_W-1:0];
        CFG_XLIM: mw_r <= cfg_data[MAPW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sx_r <= in_tdata[19:0];
      sy_r <= in_tdata[39:20];
      dx_r <= in_tdata[55:40];
      dy_r <= in_tdata[71:56];
      th_r <= in_tdata[74:72];
    end
  end

  // setup arithmetic
  always_comb begin
    ax        = dx_r[DIR_W-1] ? MAG_W'(-dx_r) : MAG_W'(dx_r);
    ay        = dy_r[DIR_W-1] ? MAG_W'(-dy_r) : MAG_W'(dy_r);
    m         = (ax > ay) ? ax : ay;
    prod      = {{LEN_W{1'b0}}, m} * {{MAG_W{1'b0}}, ll_r};
    steps_raw = prod[MAG_W+LEN_W-1:DIR_FRAC];
    steps     = (steps_raw > STEP_RAW_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
                                                     : steps_raw[LEN_W-1:0];
    start_ok  = sx_r < {mw_r, {START_FRAC{1'b0}}};
    perp_x    = -(PERP_W'(dy_r) * PERP_W'(th_r));
    perp_y    = PERP_W'(dx_r) * PERP_W'(th_r);
    sx_f      = POS_W'(sx_r) << (FRAC_BITS - START_FRAC);
    sy_f      = POS_W'(sy_r) << (FRAC_BITS - START_FRAC);
  end

  generate
    if (FRAC_BITS >= DIR_FRAC) begin : g_perp_up
      assign perp_x_f = POS_W'(perp_x) <<< (FRAC_BITS - DIR_FRAC);
      assign perp_y_f = POS_W'(perp_y) <<< (FRAC_BITS - DIR_FRAC);
    end else begin : g_perp_down
      localparam int SH = DIR_FRAC - FRAC_BITS;
      localparam logic signed [PERP_W-1:0] PRND = PERP_W'((64'd1 << SH) - 64'd1);
      logic signed [PERP_W-1:0] adj_x, adj_y;
      // truncate toward zero
      assign adj_x    = perp_x + (perp_x[PERP_W-1] ? PRND : '0);
      assign adj_y    = perp_y + (perp_y[PERP_W-1] ? PRND : '0);
      assign perp_x_f = POS_W'(adj_x >>> SH);
      assign perp_y_f = POS_W'(adj_y >>> SH);
    end
  endgenerate

  // signed increment from the divider quotient
  always_comb begin
    if (state_r == ST_DIVX) begin
      inc_w = dx_r[DIR_W-1] ? -INC_W'(div_q) : INC_W'(div_q);
    end else begin
      inc_w = dy_r[DIR_W-1] ? -INC_W'(div_q) : INC_W'(div_q);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      m_r     <= m;
      steps_r <= steps;
      pos_x_r <= sx_f + perp_x_f;
      pos_y_r <= sy_f + perp_y_f;
    end
    if (state_r == ST_DIVX && div_done) begin
      inc_x_r <= inc_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    walk_load = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (start_ok && steps != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = ax;
          div_req.divisor  = m;
          state_nxt        = ST_DIVX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = ay;
          div_req.divisor  = m_r;
          state_nxt        = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          walk_load = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!walk_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  tldda_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  tldda_walk #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (walk_load),
    .pos_x      (pos_x_r),
    .pos_y      (pos_y_r),
    .inc_x      (inc_x_r),
    .inc_y      (inc_w),
    .steps      (steps_r),
    .x_limit    (mw_r),
    .busy       (walk_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = OUT_W'({pixel_y, pixel_x});

  a_ready_walk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !walk_busy)
    else $error("request accepted while a line is still being walked");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVX || state_r == ST_DIVY))
    else $error("divider finished outside a divide state");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    walk_load |=> walk_busy)
    else $error("walker did not start after load");

endmodule

/* rtl/tldda_div.sv */
module tldda_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tldda_pkg::div_req_t  req,
  output logic                 done,
  output logic [FRAC_BITS:0]   quotient
);
  import tldda_pkg::*;

  localparam int ITER  = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam int R_W   = MAG_W + 1;

  logic [R_W-1:0]     rem_r;
  logic [MAG_W-1:0]   div_r;
  logic [FRAC_BITS:0] quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic               ge;
  logic [R_W-1:0]     diff;

  // restoring division, dividend is at most the divisor so the first
  // step needs no shift
  always_comb begin
    ge   = rem_r >= {1'b0, div_r};
    diff = ge ? rem_r - {1'b0, div_r} : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.dividend};
      div_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= {diff[R_W-2:0], 1'b0};
      quo_r <= {quo_r[FRAC_BITS-1:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/tldda_walk.sv */
module tldda_walk #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 14
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          load,
  input  logic signed [FRAC_BITS+tldda_pkg::INT_W-1:0]  pos_x,
  input  logic signed [FRAC_BITS+tldda_pkg::INT_W-1:0]  pos_y,
  input  logic signed [FRAC_BITS+1:0]                   inc_x,
  input  logic signed [FRAC_BITS+1:0]                   inc_y,
  input  logic [tldda_pkg::LEN_W-1:0]                   steps,
  input  logic [tldda_pkg::MAPW_W-1:0]                  x_limit,
  output logic                                          busy,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [COORD_BITS-1:0]                         pixel_x,
  output logic [COORD_BITS-1:0]                         pixel_y,
  output logic                                          out_tlast
);
  import tldda_pkg::*;

  localparam int POS_W = FRAC_BITS + INT_W;
  localparam int INC_W = FRAC_BITS + 2;
  localparam logic signed [POS_W-1:0] RND = POS_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [POS_W-1:0] cur_x_r, cur_y_r, limit_r;
  logic signed [INC_W-1:0] inc_x_r, inc_y_r;
  logic [LEN_W-1:0]        steps_r;
  logic                    active_r;

  logic                    out_valid_r;
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic                    last_r;

  logic signed [POS_W-1:0] nx, ny, adj_x, adj_y;
  logic signed [INT_W-1:0] int_x, int_y;
  logic                    stop, slot_free, emit, last_w;

  always_comb begin
    nx        = cur_x_r + POS_W'(inc_x_r);
    ny        = cur_y_r + POS_W'(inc_y_r);
    stop      = (steps_r == '0) || !(cur_x_r < limit_r);
    slot_free = !out_valid_r || out_tready;
    emit      = active_r && !stop && slot_free;
    last_w    = (steps_r == LEN_W'(1)) || !(nx < limit_r);
    // truncate toward zero
    adj_x     = cur_x_r + (cur_x_r[POS_W-1] ? RND : '0);
    adj_y     = cur_y_r + (cur_y_r[POS_W-1] ? RND : '0);
    int_x     = adj_x[POS_W-1:FRAC_BITS];
    int_y     = adj_y[POS_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
        steps_r  <= steps;
      end else if (active_r) begin
        if (stop || (emit && last_w)) begin
          active_r <= 1'b0;
        end
        if (emit) begin
          steps_r <= steps_r - LEN_W'(1);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x_r <= pos_x;
      cur_y_r <= pos_y;
      inc_x_r <= inc_x;
      inc_y_r <= inc_y;
      limit_r <= POS_W'({x_limit, {FRAC_BITS{1'b0}}});
    end else if (emit) begin
      cur_x_r <= nx;
      cur_y_r <= ny;
    end
    if (emit) begin
      px_r   <= COORD_BITS'(int_x);
      py_r   <= COORD_BITS'(int_y);
      last_r <= last_w;
    end
  end

  assign busy       = active_r;
  assign out_tvalid = out_valid_r;
  assign pixel_x    = px_r;
  assign pixel_y    = py_r;
  assign out_tlast  = last_r;

endmodule
